>>> design/rhp_pkg.sv
`timescale 1ns / 1ps

package rhp_pkg;

  // Configuration port
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 8;

  localparam logic [CfgIdxW-1:0] CfgMinHeaderBytes = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgMaxIdLength    = 1'b1;

  localparam logic [7:0] MinHeaderBytesRst = 8'd22;
  localparam logic [7:0] MaxIdLengthRst    = 8'd255;

  // Fixed header field sizes in bytes
  localparam logic [7:0] PrefixBytes = 8'd4;
  localparam logic [7:0] SeqBytes    = 8'd2;
  localparam logic [7:0] StageBytes  = 8'd8;
  localparam logic [7:0] ErrorBytes  = 8'd2;
  localparam logic [7:0] OrigBytes   = 8'd4;

  // Stream widths
  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 152;
  localparam int unsigned OutUserW = 2;

  typedef enum logic [1:0] {
    KIND_ID      = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_SUMMARY = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_TOO_SHORT = 2'd1,
    STATUS_BAD_ID    = 2'd2,
    STATUS_TRUNCATED = 2'd3
  } status_e;

  typedef struct packed {
    logic [7:0]  id_length;
    logic [15:0] sequence_res;
    logic [63:0] stage_id;
    logic [15:0] error_code;
    logic [31:0] original_size;
    status_e     status;
  } summary_t;

  // Up to two result beats caused by one input byte: a data beat, then a summary.
  typedef struct packed {
    logic     has_data;
    kind_e    data_kind;
    logic [7:0] data_byte;
    logic     has_sum;
    summary_t sum;
  } result_t;

endpackage

>>> design/rhp_parser.sv
`timescale 1ns / 1ps

module rhp_parser import rhp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       advance_i,
  input  logic [7:0] byte_i,
  input  logic       eop_i,
  input  logic [7:0] min_header_bytes_i,
  input  logic [7:0] max_id_length_i,
  output result_t    result_o
);

  typedef enum logic [2:0] {
    PH_PREFIX  = 3'd0,
    PH_IDLEN   = 3'd1,
    PH_ID      = 3'd2,
    PH_SEQ     = 3'd3,
    PH_STAGE   = 3'd4,
    PH_ERROR   = 3'd5,
    PH_ORIG    = 3'd6,
    PH_PAYLOAD = 3'd7
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [15:0] count_q, count_d;
  logic [7:0]  idx_q, idx_d;
  logic [7:0]  id_len_q, id_len_d;
  logic [15:0] seq_q, seq_d;
  logic [63:0] stage_q, stage_d;
  logic [15:0] err_q, err_d;
  logic [31:0] orig_q, orig_d;
  logic        bad_q, bad_d;

  logic        step_field;
  logic [7:0]  field_size;
  phase_e      field_next;
  logic [8:0]  idx_inc;

  assign idx_inc = {1'b0, idx_q} + 9'd1;

  always_comb begin
    phase_d  = phase_q;
    idx_d    = idx_q;
    id_len_d = id_len_q;
    seq_d    = seq_q;
    stage_d  = stage_q;
    err_d    = err_q;
    orig_d   = orig_q;
    bad_d    = bad_q;
    count_d  = (count_q != 16'hFFFF) ? count_q + 16'd1 : count_q;

    step_field = 1'b0;
    field_size = PrefixBytes;
    field_next = PH_IDLEN;

    result_o = '0;

    if (!bad_q) begin
      unique case (phase_q)
        PH_PREFIX: begin
          step_field = 1'b1;
          field_size = PrefixBytes;
          field_next = PH_IDLEN;
        end
        PH_IDLEN: begin
          id_len_d = byte_i;
          if (byte_i == 8'd0 || byte_i > max_id_length_i) begin
            bad_d = 1'b1;
          end else begin
            phase_d = PH_ID;
            idx_d   = 8'd0;
          end
        end
        PH_ID: begin
          result_o.has_data  = 1'b1;
          result_o.data_kind = KIND_ID;
          result_o.data_byte = byte_i;
          step_field = 1'b1;
          field_size = id_len_q;
          field_next = PH_SEQ;
        end
        PH_SEQ: begin
          for (int k = 0; k < 2; k++) begin
            if (idx_q[0] == k[0]) seq_d[8*k +: 8] = seq_q[8*k +: 8] | byte_i;
          end
          step_field = 1'b1;
          field_size = SeqBytes;
          field_next = PH_STAGE;
        end
        PH_STAGE: begin
          for (int k = 0; k < 8; k++) begin
            if (idx_q[2:0] == k[2:0]) stage_d[8*k +: 8] = stage_q[8*k +: 8] | byte_i;
          end
          step_field = 1'b1;
          field_size = StageBytes;
          field_next = PH_ERROR;
        end
        PH_ERROR: begin
          for (int k = 0; k < 2; k++) begin
            if (idx_q[0] == k[0]) err_d[8*k +: 8] = err_q[8*k +: 8] | byte_i;
          end
          step_field = 1'b1;
          field_size = ErrorBytes;
          field_next = PH_ORIG;
        end
        PH_ORIG: begin
          for (int k = 0; k < 4; k++) begin
            if (idx_q[1:0] == k[1:0]) orig_d[8*k +: 8] = orig_q[8*k +: 8] | byte_i;
          end
          step_field = 1'b1;
          field_size = OrigBytes;
          field_next = PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          result_o.has_data  = 1'b1;
          result_o.data_kind = KIND_PAYLOAD;
          result_o.data_byte = byte_i;
        end
        default: begin
          result_o.has_data = 1'b0;
        end
      endcase
    end

    if (step_field) begin
      if (idx_inc >= {1'b0, field_size}) begin
        idx_d   = 8'd0;
        phase_d = field_next;
      end else begin
        idx_d = idx_inc[7:0];
      end
    end

    if (eop_i) begin
      result_o.has_sum           = 1'b1;
      result_o.sum.id_length     = id_len_d;
      result_o.sum.sequence_res  = seq_d;
      result_o.sum.stage_id      = stage_d;
      result_o.sum.error_code    = err_d;
      result_o.sum.original_size = orig_d;
      priority if (count_d < {8'd0, min_header_bytes_i}) begin
        result_o.sum.status = STATUS_TOO_SHORT;
      end else if (bad_d) begin
        result_o.sum.status = STATUS_BAD_ID;
      end else if (phase_d != PH_PAYLOAD) begin
        result_o.sum.status = STATUS_TRUNCATED;
      end else begin
        result_o.sum.status = STATUS_OK;
      end
      phase_d  = PH_PREFIX;
      count_d  = '0;
      idx_d    = '0;
      id_len_d = '0;
      seq_d    = '0;
      stage_d  = '0;
      err_d    = '0;
      orig_d   = '0;
      bad_d    = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_PREFIX;
      count_q  <= '0;
      idx_q    <= '0;
      id_len_q <= '0;
      seq_q    <= '0;
      stage_q  <= '0;
      err_q    <= '0;
      orig_q   <= '0;
      bad_q    <= 1'b0;
    end else if (advance_i) begin
      phase_q  <= phase_d;
      count_q  <= count_d;
      idx_q    <= idx_d;
      id_len_q <= id_len_d;
      seq_q    <= seq_d;
      stage_q  <= stage_d;
      err_q    <= err_d;
      orig_q   <= orig_d;
      bad_q    <= bad_d;
    end
  end

endmodule

>>> design/rhp_out_buf.sv
`timescale 1ns / 1ps

module rhp_out_buf import rhp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  result_t             result_i,
  output logic                can_load_o,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [OutDataW-1:0] m_axis_tdata_o,
  output logic [OutUserW-1:0] m_axis_tuser_o,
  output logic                m_axis_tlast_o
);

  logic       has_data_q, has_data_d;
  logic       has_sum_q, has_sum_d;
  kind_e      data_kind_q;
  logic [7:0] data_byte_q;
  summary_t   sum_q;
  logic       pop;

  assign m_axis_tvalid_o = has_data_q | has_sum_q;
  assign pop             = m_axis_tvalid_o & m_axis_tready_i;
  // Free after this cycle if empty, or if the only pending beat leaves now.
  assign can_load_o      = !m_axis_tvalid_o || (pop && !(has_data_q && has_sum_q));

  assign m_axis_tuser_o = has_data_q ? data_kind_q : KIND_SUMMARY;
  assign m_axis_tlast_o = !has_data_q && has_sum_q;

  always_comb begin
    m_axis_tdata_o = '0;
    if (has_data_q) begin
      m_axis_tdata_o[7:0] = data_byte_q;
    end else begin
      m_axis_tdata_o[15:8]    = sum_q.id_length;
      m_axis_tdata_o[31:16]   = sum_q.sequence_res;
      m_axis_tdata_o[95:32]   = sum_q.stage_id;
      m_axis_tdata_o[111:96]  = sum_q.error_code;
      m_axis_tdata_o[143:112] = sum_q.original_size;
      m_axis_tdata_o[145:144] = sum_q.status;
    end
  end

  always_comb begin
    has_data_d = has_data_q;
    has_sum_d  = has_sum_q;
    if (load_i) begin
      has_data_d = result_i.has_data;
      has_sum_d  = result_i.has_sum;
    end else if (pop) begin
      if (has_data_q) begin
        has_data_d = 1'b0;
      end else begin
        has_sum_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      has_data_q <= 1'b0;
      has_sum_q  <= 1'b0;
    end else begin
      has_data_q <= has_data_d;
      has_sum_q  <= has_sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_kind_q <= result_i.data_kind;
      data_byte_q <= result_i.data_byte;
      sum_q       <= result_i.sum;
    end
  end

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> can_load_o)
    else $error("result register loaded while a beat is still pending");

  a_sum_follows_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && has_data_q && has_sum_q) |=> (m_axis_tvalid_o && m_axis_tlast_o))
    else $error("summary lost after its data beat");

  a_summary_marked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tlast_o) |->
      (m_axis_tuser_o == KIND_SUMMARY && m_axis_tdata_o[7:0] == 8'd0))
    else $error("summary beat with wrong kind or nonzero data byte");

endmodule

>>> design/response_header_parser.sv
`timescale 1ns / 1ps
// Path: a byte beat waits in the input register until the result register can take its
//   results; its result beats then leave from the result register.
// Throughput: one byte beat per cycle while the result stream is ready; a closing byte
//   with an id or payload byte yields two result beats; input then waits for the summary.
// Reset: all packet state cleared, min_header_bytes = 22, max_id_length = 255, no beats.

module response_header_parser import rhp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Configuration: register 0 min_header_bytes, register 1 max_id_length
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  // Byte stream in
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [InDataW-1:0]  s_axis_tdata_i,   // [7:0] byte_value
  input  logic                s_axis_tlast_i,   // end_of_packet
  // Result stream out
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // [7:0] data_byte, [15:8] id_length, [31:16] sequence_res, [95:32] stage_id,
  // [111:96] error_code, [143:112] original_size, [145:144] status, rest zero
  output logic [OutDataW-1:0] m_axis_tdata_o,
  output logic [OutUserW-1:0] m_axis_tuser_o,   // [1:0] kind
  output logic                m_axis_tlast_o    // last
);

  // Configuration registers; the user must write them only while idle; the block does not enforce this.
  logic [7:0] min_hdr_q;
  logic [7:0] max_id_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_hdr_q <= MinHeaderBytesRst;
      max_id_q  <= MaxIdLengthRst;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgMinHeaderBytes: min_hdr_q <= cfg_data_i;
        CfgMaxIdLength:    max_id_q  <= cfg_data_i;
        default:           max_id_q  <= max_id_q;
      endcase
    end
  end

  // Input register: holds one byte beat until the parser can hand its results on.
  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q;
  logic       in_eop_q;
  logic       s_accept;
  logic       advance;
  logic       can_load;
  result_t    result;

  // Advance the parser whenever a byte waits and the result register frees up.
  assign advance         = in_valid_q && can_load;
  assign s_axis_tready_o = !in_valid_q || advance;
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_byte_q <= s_axis_tdata_i;
      in_eop_q  <= s_axis_tlast_i;
    end
  end

  // Packet state and per-byte decode.
  rhp_parser u_parser (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .advance_i          (advance),
    .byte_i             (in_byte_q),
    .eop_i              (in_eop_q),
    .min_header_bytes_i (min_hdr_q),
    .max_id_length_i    (max_id_q),
    .result_o           (result)
  );

  // Result register: emit the data beat first, then the summary.
  rhp_out_buf u_out_buf (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (advance),
    .result_i        (result),
    .can_load_o      (can_load),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule
